### rtl/core/udc_pkg.sv
`default_nettype none

package udc_pkg;

  localparam int unsigned NumButtons = 4;
  localparam int unsigned CountW     = 16;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned CfgW       = 16;

  localparam logic [CountW-1:0] CountLimitReset = 16'd9999;
  localparam logic [CfgW-1:0]   IntervalReset   = 16'd600;

  typedef enum logic [1:0] {
    MODE_PAUSED = 2'd0,
    MODE_UP     = 2'd1,
    MODE_DOWN   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_UP    = 3'd1,
    CMD_DOWN  = 3'd2,
    CMD_PAUSE = 3'd3,
    CMD_RESET = 3'd4
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_COUNT_LIMIT = 1'b0,
    REG_INTERVAL    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [NumButtons-1:0] prior_levels;
    mode_t                 run_mode;
    mode_t                 resume_direction;
    logic [CountW-1:0]     count_value;
    logic [TimeW-1:0]      last_step_ms;
  } state_t;

  typedef struct packed {
    logic [CountW-1:0] count_out;
    logic [1:0]        mode_out;
    logic [2:0]        command_out;
    logic              count_changed;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/udc_in_if.sv
`default_nettype none

interface udc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  button_levels;
  logic [31:0] now_ms;

  modport source (output valid, output button_levels, output now_ms, input ready);
  modport sink (input valid, input button_levels, input now_ms, output ready);
endinterface

`default_nettype wire

### rtl/core/udc_out_if.sv
`default_nettype none

interface udc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] count_out;
  logic [1:0]  mode_out;
  logic [2:0]  command_out;
  logic        count_changed;

  modport source (output valid, output count_out, output mode_out, output command_out,
                  output count_changed, input ready);
  modport sink (input valid, input count_out, input mode_out, input command_out,
                input count_changed, output ready);
endinterface

`default_nettype wire

### rtl/core/udc_step.sv
`default_nettype none

module udc_step (
  input  udc_pkg::state_t                   state,
  input  logic [udc_pkg::NumButtons-1:0]    levels,
  input  logic [udc_pkg::TimeW-1:0]         now,
  input  logic [udc_pkg::CountW-1:0]        count_limit,
  input  logic [udc_pkg::CfgW-1:0]          interval_ms,
  output udc_pkg::state_t                   state_next,
  output udc_pkg::result_t                  result
);
  import udc_pkg::*;

  logic [NumButtons-1:0] edges;
  cmd_t                  cmd;
  mode_t                 mode_cmd;
  mode_t                 resume_cmd;
  logic [CountW-1:0]     count_cmd;
  logic                  cleared;
  logic [TimeW-1:0]      elapsed;
  logic                  due;
  logic                  step_up;
  logic                  step_down;
  logic [CountW-1:0]     count_new;

  // A falling edge is a released level followed by a pressed one.
  assign edges = state.prior_levels & ~levels;

  always_comb begin
    if (edges[3]) begin
      cmd = CMD_RESET;
    end else if (edges[2]) begin
      cmd = CMD_PAUSE;
    end else if (edges[1]) begin
      cmd = CMD_DOWN;
    end else if (edges[0]) begin
      cmd = CMD_UP;
    end else begin
      cmd = CMD_NONE;
    end
  end

  always_comb begin
    mode_cmd   = state.run_mode;
    resume_cmd = state.resume_direction;
    count_cmd  = state.count_value;
    cleared    = 1'b0;
    case (cmd)
      CMD_UP: begin
        mode_cmd   = MODE_UP;
        resume_cmd = MODE_UP;
      end
      CMD_DOWN: begin
        mode_cmd   = MODE_DOWN;
        resume_cmd = MODE_DOWN;
      end
      CMD_PAUSE: begin
        mode_cmd = (state.run_mode == MODE_PAUSED) ? state.resume_direction : MODE_PAUSED;
      end
      CMD_RESET: begin
        count_cmd = '0;
        cleared   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Wrapping time difference against the last step time.
  assign elapsed   = now - state.last_step_ms;
  assign due       = (elapsed >= {{(TimeW-CfgW){1'b0}}, interval_ms});
  assign step_up   = due && (mode_cmd == MODE_UP) && (count_cmd < count_limit);
  assign step_down = due && (mode_cmd == MODE_DOWN) && (count_cmd != '0);

  always_comb begin
    if (step_up) begin
      count_new = count_cmd + 1'b1;
    end else if (step_down) begin
      count_new = count_cmd - 1'b1;
    end else begin
      count_new = count_cmd;
    end
  end

  always_comb begin
    state_next.prior_levels     = levels;
    state_next.run_mode         = mode_cmd;
    state_next.resume_direction = resume_cmd;
    state_next.count_value      = count_new;
    state_next.last_step_ms     = due ? now : state.last_step_ms;
  end

  assign result.count_out     = count_new;
  assign result.mode_out      = mode_cmd;
  assign result.command_out   = cmd;
  assign result.count_changed = cleared | step_up | step_down;

endmodule

`default_nettype wire

### rtl/core/up_down_counter_with_pause.sv
// Channel   Direction  Payload
// cfg_*     in         cfg_index selects count_limit or interval_ms, cfg_data is the value
// sample    in         button_levels, now_ms
// result    out        count_out, mode_out, command_out, count_changed
//
// One request is taken per cycle while the output register is free; its result appears
// in the output register on the next cycle. The state update and the 32-bit elapsed-time
// compare are combinational. A request is taken whenever the output register is empty or
// is being emptied, so a stalled result holds back only the next request. Reset is
// synchronous and restores the registers, the state and an empty output register.
`default_nettype none

module up_down_counter_with_pause (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [udc_pkg::CfgW-1:0]    cfg_data,
  udc_in_if.sink                      sample,
  udc_out_if.source                   result
);
  import udc_pkg::*;

  logic [CountW-1:0] count_limit;
  logic [CfgW-1:0]   interval_ms;
  state_t            state;
  state_t            state_next;
  result_t           res_next;
  result_t           res;
  logic              res_valid;
  logic              take;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit <= CountLimitReset;
      interval_ms <= IntervalReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT_LIMIT: count_limit <= cfg_data;
        REG_INTERVAL:    interval_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  udc_step u_step (
    .state       (state),
    .levels      (sample.button_levels),
    .now         (sample.now_ms),
    .count_limit (count_limit),
    .interval_ms (interval_ms),
    .state_next  (state_next),
    .result      (res_next)
  );

  assign sample.ready = !res_valid || result.ready;
  assign take         = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.prior_levels     <= '1;
      state.run_mode         <= MODE_PAUSED;
      state.resume_direction <= MODE_UP;
      state.count_value      <= '0;
      state.last_step_ms     <= '0;
      res_valid              <= 1'b0;
    end else begin
      if (take) begin
        state <= state_next;
      end
      if (take) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.count_out     = res.count_out;
  assign result.mode_out      = res.mode_out;
  assign result.command_out   = res.command_out;
  assign result.count_changed = res.count_changed;

endmodule

`default_nettype wire

### tb/sv/udc_check_pkg.sv
`timescale 1ns / 1ps

package udc_check_pkg;
  import udc_pkg::*;

  class count_scoreboard;
    logic [CountW-1:0]     limit;
    logic [CfgW-1:0]       interval;
    logic [NumButtons-1:0] prior_levels;
    mode_t                 run_mode;
    mode_t                 resume_dir;
    logic [CountW-1:0]     count;
    logic [TimeW-1:0]      last_step_ms;
    result_t               pending_counts[$];
    int unsigned           mismatches;

    function new();
      mismatches   = 0;
      limit        = CountLimitReset;
      interval     = IntervalReset;
      prior_levels = '1;
      run_mode     = MODE_PAUSED;
      resume_dir   = MODE_UP;
      count        = '0;
      last_step_ms = '0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CfgW-1:0] value);
      case (idx)
        REG_COUNT_LIMIT: limit = value;
        REG_INTERVAL:    interval = value;
        default: ;
      endcase
    endfunction

    // Advances the counter by one accepted request and queues the result it should give.
    function void note_sample(logic [NumButtons-1:0] levels, logic [TimeW-1:0] now);
      cmd_t    cmd;
      logic    changed;
      result_t expected;
      cmd     = CMD_NONE;
      changed = 1'b0;
      // The highest-numbered falling edge wins.
      for (int i = 0; i < NumButtons; i++) begin
        if (prior_levels[i] && !levels[i]) begin
          cmd = cmd_t'(i + 1);
        end
      end
      prior_levels = levels;
      case (cmd)
        CMD_UP: begin
          resume_dir = MODE_UP;
          run_mode   = MODE_UP;
        end
        CMD_DOWN: begin
          resume_dir = MODE_DOWN;
          run_mode   = MODE_DOWN;
        end
        CMD_PAUSE: begin
          run_mode = (run_mode == MODE_PAUSED) ? resume_dir : MODE_PAUSED;
        end
        CMD_RESET: begin
          count   = '0;
          changed = 1'b1;
        end
        default: ;
      endcase
      if (TimeW'(now - last_step_ms) >= TimeW'(interval)) begin
        if (run_mode == MODE_UP && count < limit) begin
          count   = count + 1'b1;
          changed = 1'b1;
        end else if (run_mode == MODE_DOWN && count != '0) begin
          count   = count - 1'b1;
          changed = 1'b1;
        end
        last_step_ms = now;
      end
      expected.count_out     = count;
      expected.mode_out      = run_mode;
      expected.command_out   = cmd;
      expected.count_changed = changed;
      pending_counts.push_back(expected);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_counts.size() == 0) begin
        $error("result with no request waiting: count_out %0d", got.count_out);
        mismatches++;
        return;
      end
      want = pending_counts.pop_front();
      compare_field("count_out", want.count_out, got.count_out);
      compare_field("mode_out", want.mode_out, got.mode_out);
      compare_field("command_out", want.command_out, got.command_out);
      compare_field("count_changed", want.count_changed, got.count_changed);
    endfunction

    function int unsigned outstanding();
      return pending_counts.size();
    endfunction
  endclass

endpackage

### tb/sv/up_down_counter_with_pause_tb.sv
`timescale 1ns / 1ps

module up_down_counter_with_pause_tb;
  import udc_pkg::*;
  import udc_check_pkg::*;

  localparam int unsigned CycleLimit      = 200000;
  localparam int unsigned ItemsPerSegment = 275;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  reg_idx_t              cfg_index;
  logic [CfgW-1:0]       cfg_data;
  int unsigned           src_idle_pct;
  int unsigned           sink_idle_pct;
  int unsigned           cycles = 0;
  logic [TimeW-1:0]      wall_ms;
  count_scoreboard       board = new();

  udc_in_if  sample ();
  udc_out_if result ();

  up_down_counter_with_pause uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sample   (sample),
    .result   (result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("up_down_counter_with_pause verification failed");
      $finish;
    end
  end

  // Result side: check every accepted result and stall at random.
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready) begin
        board.check_result(result_t'{result.count_out, result.mode_out,
                                     result.command_out, result.count_changed});
      end
      result.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_sample(input logic [NumButtons-1:0] levels,
                             input logic [TimeW-1:0] now);
    if ($urandom_range(99) < src_idle_pct) begin
      sample.valid         <= 1'b0;
      sample.button_levels <= NumButtons'($urandom);
      sample.now_ms        <= $urandom;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    sample.valid         <= 1'b1;
    sample.button_levels <= levels;
    sample.now_ms        <= now;
    do @(posedge clk); while (!sample.ready);
    board.note_sample(levels, now);
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // Registers are only written once every outstanding result has been taken.
  task automatic set_registers(input logic [CfgW-1:0] limit, input logic [CfgW-1:0] interval);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_COUNT_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    board.write_reg(REG_COUNT_LIMIT, limit);
    cfg_index <= REG_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    board.write_reg(REG_INTERVAL, interval);
    cfg_we <= 1'b0;
  endtask

  task automatic send_directed();
    send_sample(4'b1111, 32'd0);
    send_sample(4'b1110, 32'd600);
    send_sample(4'b1111, 32'd1199);
    send_sample(4'b1111, 32'd1200);
    send_sample(4'b1011, 32'd1300);
    // Interval passes while paused: no step, but the step time moves on.
    send_sample(4'b1111, 32'd1900);
    send_sample(4'b1011, 32'd1901);
    send_sample(4'b1101, 32'd2500);
    send_sample(4'b1111, 32'd3100);
    send_sample(4'b1111, 32'd3700);
    send_sample(4'b0000, 32'd3701);
    send_sample(4'b1111, 32'd3702);
    send_sample(4'b1100, 32'd4400);
    send_sample(4'b1111, 32'd4401);
    send_sample(4'b1110, 32'hFFFF_FFF0);
    // Time wraps past zero; the elapsed time is taken modulo 2^32.
    send_sample(4'b1111, 32'h0000_0100);
    send_sample(4'b1111, 32'h0000_0250);
    send_sample(4'b0111, 32'h0000_04A8);
    send_sample(4'b1111, 32'h0000_04A9);
    send_sample(4'b1010, 32'h0000_0500);
    send_sample(4'b1111, 32'h0000_0501);
    send_sample(4'b1011, 32'hFFFF_FFFF);
    wall_ms = 32'hFFFF_FFFF;
  endtask

  task automatic send_random(input int unsigned count);
    logic [NumButtons-1:0] levels;
    int unsigned           button;
    int unsigned           pick;
    repeat (count) begin
      levels = board.prior_levels;
      // The reset button is pressed rarely so that the count can build up.
      button = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
      pick   = $urandom_range(99);
      if (pick < 35) begin
        levels[button] = 1'b0;
      end else if (pick < 80) begin
        levels = levels | NumButtons'($urandom);
      end else if (pick < 90) begin
        levels = NumButtons'($urandom);
      end
      case ($urandom_range(19))
        0: wall_ms = $urandom;
        1: wall_ms = board.last_step_ms + board.interval;
        2: wall_ms = board.last_step_ms + board.interval - 1;
        default: wall_ms = wall_ms + $urandom_range(2 * board.interval + 1);
      endcase
      send_sample(levels, wall_ms);
    end
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_COUNT_LIMIT;
    cfg_data             <= '0;
    sample.valid         <= 1'b0;
    sample.button_levels <= '1;
    sample.now_ms        <= '0;
    src_idle_pct  = 34;
    sink_idle_pct = 88;
    wall_ms       = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_directed();
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: set_registers(16'hFFFF, 16'd1);
        1: set_registers(16'd7, 16'd0);
        2: set_registers(16'd0, 16'd5);
        3: set_registers(16'd1, 16'hFFFF);
        4: set_registers(16'd300, 16'd2);
        default: set_registers(16'd9999, 16'd600);
      endcase
      case (seg / 2)
        0: begin
          src_idle_pct  = 34;
          sink_idle_pct = 88;
        end
        1: begin
          src_idle_pct  = 88;
          sink_idle_pct = 34;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      send_random(ItemsPerSegment);
    end
    drain();
    repeat (5) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("up_down_counter_with_pause verification clean");
    end else begin
      $display("up_down_counter_with_pause verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/udc_pkg.sv
rtl/core/udc_in_if.sv
rtl/core/udc_out_if.sv
rtl/core/udc_step.sv
rtl/core/up_down_counter_with_pause.sv
tb/sv/udc_check_pkg.sv
tb/sv/up_down_counter_with_pause_tb.sv
